/* design/fph_pkg.sv */
// Shared types, constants and the sequencer program of the four-point homography block.
// No dependencies; imported by every module of the block.
`default_nettype none
package fph_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 32;
    localparam int ENTRY_W           = 64;
    localparam int M_TDATA_W         = 72;

    // register file map
    localparam int NREG  = 57;
    localparam int RA_W  = 6;
    localparam int NPROG = 184;
    localparam int PC_W  = 8;

    localparam int R_T1  = 24;
    localparam int R_T2  = 25;
    localparam int R_DEN = 55;
    localparam int R_ACC = 56;

    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]      op;
        logic            chk;
        logic [RA_W-1:0] dst;
        logic [RA_W-1:0] a;
        logic [RA_W-1:0] b;
    } instr_t;

    typedef instr_t [NPROG-1:0] prog_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } arith_ctl_t;

    function automatic instr_t mk(logic [1:0] op, logic chk, int dst, int a, int b);
        instr_t t;
        t.op  = op;
        t.chk = chk;
        t.dst = RA_W'(dst);
        t.a   = RA_W'(a);
        t.b   = RA_W'(b);
        return t;
    endfunction

    // Cross products of point pairs, then determinants as dot products, the
    // weights dd_k*ds_k+1*ds_k+2, the common denominator and the nine entries.
    function automatic prog_t build_prog();
        prog_t p;
        int n;
        int j;
        int l;
        int k1;
        int k2;
        int cd [6] = '{26, 29, 32, 35, 38, 41};
        int cp [6] = '{3, 6, 0, 15, 18, 12};
        int cq [6] = '{6, 0, 3, 18, 12, 15};
        int dd [8] = '{44, 45, 46, 47, 48, 49, 50, 51};
        int dp [8] = '{0, 9, 9, 9, 12, 21, 21, 21};
        int dq [8] = '{26, 26, 29, 32, 35, 35, 38, 41};
        n = 0;
        for (int g = 0; g < 6; g++) begin
            for (int i = 0; i < 3; i++) begin
                j = (i == 2) ? 0 : i + 1;
                l = (j == 2) ? 0 : j + 1;
                p[n] = mk(OP_MUL, 1'b0, R_T1, cp[g] + j, cq[g] + l); n++;
                p[n] = mk(OP_MUL, 1'b0, R_T2, cp[g] + l, cq[g] + j); n++;
                p[n] = mk(OP_SUB, 1'b0, cd[g] + i, R_T1, R_T2);    n++;
            end
        end
        for (int g = 0; g < 8; g++) begin
            p[n] = mk(OP_MUL, 1'b0, R_T1, dq[g], dp[g]);         n++;
            p[n] = mk(OP_MUL, 1'b0, R_T2, dq[g] + 1, dp[g] + 1); n++;
            p[n] = mk(OP_ADD, 1'b0, R_T1, R_T1, R_T2);           n++;
            p[n] = mk(OP_MUL, 1'b0, R_T2, dq[g] + 2, dp[g] + 2); n++;
            p[n] = mk(OP_ADD, 1'b1, dd[g], R_T1, R_T2);          n++;
        end
        for (int k = 0; k < 3; k++) begin
            k1 = (k == 2) ? 0 : k + 1;
            k2 = (k1 == 2) ? 0 : k1 + 1;
            p[n] = mk(OP_MUL, 1'b0, R_T1, 45 + k1, 45 + k2); n++;
            p[n] = mk(OP_MUL, 1'b0, 52 + k, R_T1, 49 + k);   n++;
        end
        p[n] = mk(OP_MUL, 1'b0, R_T1, 45, 46);     n++;
        p[n] = mk(OP_MUL, 1'b0, R_T2, R_T1, 47);   n++;
        p[n] = mk(OP_MUL, 1'b0, R_DEN, R_T2, 48);  n++;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    p[n] = mk(OP_MUL, 1'b0, R_T1, 26 + 3 * k + c, 12 + 3 * k + r); n++;
                    p[n] = mk(OP_MUL, 1'b0, (k == 0) ? R_ACC : R_T2, 52 + k, R_T1); n++;
                    if (k > 0) begin
                        p[n] = mk(OP_ADD, 1'b0, R_ACC, R_ACC, R_T2); n++;
                    end
                end
                p[n] = mk(OP_DIV, 1'b0, R_ACC, R_ACC, R_DEN); n++;
            end
        end
        return p;
    endfunction

endpackage
`default_nettype wire

/* design/fph_arith.sv */
// Shared bit-serial multiplier and restoring divider with one wide adder.
// Depends on fph_pkg for the control struct and the entry width.
`default_nettype none
module fph_arith #(
    parameter int BW = 196,
    parameter int DW = 258,
    parameter int FB = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire fph_pkg::arith_ctl_t           ctl,
    input  wire logic signed [BW-1:0]          opa,
    input  wire logic signed [BW-1:0]          opb,
    output logic                               done,
    output logic signed [BW-1:0]               product,
    output logic [fph_pkg::ENTRY_W-1:0]        quotient
);
    import fph_pkg::*;

    localparam int CNT_W = $clog2(ENTRY_W + 1);

    logic [DW-1:0]    x_reg, x_next;
    logic [DW-1:0]    z_reg, z_next;
    logic [BW-1:0]    y_reg, y_next;
    logic [ENTRY_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             ovf_reg, ovf_next;
    logic             div_reg, div_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [BW-1:0]    mag_a, mag_b;
    logic [DW:0]      sum;
    logic             ge;
    logic [BW-1:0]    zlow;

    localparam logic [ENTRY_W-1:0] MAXP = {1'b0, {(ENTRY_W-1){1'b1}}};
    localparam logic [ENTRY_W-1:0] MINN = {1'b1, {(ENTRY_W-1){1'b0}}};

    assign mag_a = opa[BW-1] ? (~opa + 1'b1) : opa;
    assign mag_b = opb[BW-1] ? (~opb + 1'b1) : opb;

    // add for multiply, subtract for divide; carry out means no borrow
    assign sum = {1'b0, z_reg} + {1'b0, (div_reg ? ~x_reg : x_reg)} + (DW+1)'(div_reg);
    assign ge  = sum[DW];

    always_comb begin
        x_next    = x_reg;
        z_next    = z_reg;
        y_next    = y_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        div_next  = div_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start) begin
            busy_next = 1'b1;
            div_next  = ctl.is_div;
            neg_next  = opa[BW-1] ^ opb[BW-1];
            cnt_next  = '0;
            ovf_next  = 1'b0;
            y_next    = mag_b;
            if (ctl.is_div) begin
                z_next = (DW'(mag_a) << (FB + 1)) + DW'(mag_b);
                x_next = DW'(mag_b) << (ENTRY_W + 1);
            end else begin
                z_next = '0;
                x_next = DW'(mag_a);
            end
        end else if (busy_reg) begin
            if (div_reg) begin
                // first compare detects a quotient too wide for the entry
                if (cnt_reg == '0) begin
                    ovf_next = ge;
                end else begin
                    if (ge) begin
                        z_next = sum[DW-1:0];
                    end
                    q_next = {q_reg[ENTRY_W-2:0], ge};
                end
                x_next   = x_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ENTRY_W)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end else begin
                if (y_reg == '0) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    if (y_reg[0]) begin
                        z_next = sum[DW-1:0];
                    end
                    x_next = x_reg << 1;
                    y_next = y_reg >> 1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg   <= x_next;
        z_reg   <= z_next;
        y_reg   <= y_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        div_reg <= div_next;
    end

    assign zlow    = z_reg[BW-1:0];
    assign product = neg_reg ? (~zlow + 1'b1) : zlow;
    assign done    = done_reg;

    always_comb begin
        if (ovf_reg) begin
            quotient = neg_reg ? MINN : MAXP;
        end else if (neg_reg) begin
            quotient = (q_reg > MINN) ? MINN : (~q_reg + 1'b1);
        end else begin
            quotient = q_reg[ENTRY_W-1] ? MAXP : q_reg;
        end
    end

endmodule
`default_nettype wire

/* design/four_point_homography.sv */
// Four-point homography: top level with sequencer, register file and stream ports.
// Depends on fph_pkg and fph_arith.
//
// Each input word carries one correspondence; a word is taken in ST_IDLE and its
// six coordinates are then stored one at a time in ST_LOAD through the single
// write port of the register file. The fourth word starts a program of 184
// steps run by one shared bit-serial multiplier and 65-step divider. A multiply
// is fetched and started, steps once per significant bit of its second operand,
// then finishes and is written back; an add is fetched and then executed and
// written back, and a divide is fetched, started and run to its quotient.
// The nine entries are produced one at a time in row-major order; each is held
// in the output register until taken, and the next entry is computed only after
// that. The input is not ready from the fourth word until the ninth entry is taken.
`default_nettype none
module four_point_homography #(
    parameter int COORD_WIDTH   = fph_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = fph_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // src_x, src_y, src_w, dst_x, dst_y, dst_w, zero fill
    input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // row, col, entry, zero fill
    output logic [fph_pkg::M_TDATA_W-1:0]              m_tdata,
    // degenerate
    output logic                                       m_tuser,
    output logic                                       m_tlast
);
    import fph_pkg::*;

    localparam int BW = 12 * COORD_WIDTH + 4;
    localparam int DW = 12 * COORD_WIDTH + 66;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam prog_t PROG = build_prog();

    logic [2:0]      state_reg, state_next;
    logic [1:0]      slot_reg, slot_next;
    logic [2:0]      lcnt_reg, lcnt_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            bad_reg, bad_next;
    logic [1:0]      row_reg, row_next;
    logic [1:0]      col_reg, col_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;

    logic [COORD_WIDTH-1:0] coord_reg [6];
    logic signed [BW-1:0]   rf [NREG];
    logic signed [BW-1:0]   rda_reg, rdb_reg;

    instr_t               instr;
    logic                 rf_we;
    logic [RA_W-1:0]      rf_waddr;
    logic signed [BW-1:0] rf_wdata;
    logic signed [BW-1:0] addsub;
    logic                 s_acc, m_acc;

    arith_ctl_t           ctl;
    logic                 arith_done;
    logic signed [BW-1:0] product;
    logic [ENTRY_W-1:0]   quotient;

    fph_arith #(
        .BW(BW),
        .DW(DW),
        .FB(FRACTION_BITS)
    ) u_arith (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .opa      (rda_reg),
        .opb      (rdb_reg),
        .done     (arith_done),
        .product  (product),
        .quotient (quotient)
    );

    assign instr  = PROG[pc_reg];
    assign s_acc  = s_tvalid && s_tready;
    assign m_acc  = m_tvalid && m_tready;
    assign addsub = (instr.op == OP_SUB) ? (rda_reg - rdb_reg) : (rda_reg + rdb_reg);

    assign ctl.start  = (state_reg == ST_EXEC) &&
                        ((instr.op == OP_MUL) || (instr.op == OP_DIV));
    assign ctl.is_div = (instr.op == OP_DIV);

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        lcnt_next  = lcnt_reg;
        pc_next    = pc_reg;
        bad_next   = bad_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        entry_next = entry_reg;
        rf_we      = 1'b0;
        rf_waddr   = instr.dst;
        rf_wdata   = addsub;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    lcnt_next  = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                rf_we    = 1'b1;
                rf_waddr = RA_W'(slot_reg) * RA_W'(3) + RA_W'(lcnt_reg) +
                           ((lcnt_reg < 3'd3) ? RA_W'(0) : RA_W'(9));
                rf_wdata = BW'($signed(coord_reg[lcnt_reg]));
                lcnt_next = lcnt_reg + 1'b1;
                if (lcnt_reg == 3'd5) begin
                    if (slot_reg == 2'd3) begin
                        slot_next  = '0;
                        pc_next    = '0;
                        bad_next   = 1'b0;
                        row_next   = '0;
                        col_next   = '0;
                        state_next = ST_FETCH;
                    end else begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (instr.op)
                    OP_ADD, OP_SUB: begin
                        rf_we      = 1'b1;
                        pc_next    = pc_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                    default: begin
                        state_next = ST_WAIT;
                    end
                endcase
            end
            ST_WAIT: begin
                if (arith_done) begin
                    if (instr.op == OP_DIV) begin
                        entry_next = bad_reg ? '0 : quotient;
                        state_next = ST_OUT;
                    end else begin
                        rf_we      = 1'b1;
                        rf_wdata   = product;
                        pc_next    = pc_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_OUT: begin
                if (m_acc) begin
                    if (col_reg == 2'd2) begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                    if (row_reg == 2'd2 && col_reg == 2'd2) begin
                        state_next = ST_IDLE;
                    end else begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // flag a zero determinant
        if (rf_we && instr.chk && (state_reg != ST_LOAD) && (rf_wdata == '0)) begin
            bad_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            lcnt_reg  <= '0;
            pc_reg    <= '0;
            bad_reg   <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            lcnt_reg  <= lcnt_next;
            pc_reg    <= pc_next;
            bad_reg   <= bad_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
        entry_reg <= entry_next;
    end

    // hold the accepted word until it is written out
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int i = 0; i < 6; i++) begin
                coord_reg[i] <= s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf[rf_waddr] <= rf_wdata;
        end
        if (state_reg == ST_FETCH) begin
            rda_reg <= rf[instr.a];
            rdb_reg <= rf[instr.b];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {{(M_TDATA_W - ENTRY_W - 4){1'b0}}, entry_reg, col_reg, row_reg};
    assign m_tuser  = bad_reg;
    assign m_tlast  = (row_reg == 2'd2) && (col_reg == 2'd2);

endmodule
`default_nettype wire

/* design/fph_checker.sv */
// Port-level checks of the four-point homography block, bound to its top level.
// Depends on fph_pkg for the output word width.
`default_nettype none
module fph_checker #(
    parameter int COORD_WIDTH = fph_pkg::COORD_WIDTH_DEF
) (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [fph_pkg::M_TDATA_W-1:0]      m_tdata,
    input wire logic                               m_tuser,
    input wire logic                               m_tlast
);
    import fph_pkg::*;

    logic unused_in;
    assign unused_in = ^{s_tvalid, s_tdata};

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[ENTRY_W+3:4] == '0)
        else $error("degenerate set with nonzero entry");

    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[1:0] == 2'd2 && m_tdata[3:2] == 2'd2)
        else $error("last flag off the final entry");

endmodule

bind four_point_homography fph_checker #(.COORD_WIDTH(COORD_WIDTH)) u_fph_checker (.*);
`default_nettype wire
